// ----- src/xtkd_pkg.sv -----
// Package for the xorshift table key derivation block.
// Holds the sizes, default seeds, generator step function, sequencer states and control types.
// It depends on nothing else and is imported by every module of the block.
package xtkd_pkg;

    localparam int KEY_WORDS      = 4;
    localparam int BYTES_PER_WORD = 4;
    localparam int TABLE_DEPTH    = 64;
    localparam int TABLE_AW       = 6;
    localparam int WORD_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int BYTE_CNT_W     = 2;
    localparam int WORD_CNT_W     = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

    localparam logic [WORD_W-1:0] DEFAULT_SEED_A = 32'h0000_0001;
    localparam logic [WORD_W-1:0] DEFAULT_SEED_B = 32'h6C07_8967;
    localparam logic [WORD_W-1:0] DEFAULT_SEED_C = 32'h714A_CB41;
    localparam logic [WORD_W-1:0] DEFAULT_SEED_D = 32'h4807_7044;

    localparam int SHIFT_LEFT_A  = 11;
    localparam int SHIFT_RIGHT_B = 8;
    localparam int SHIFT_RIGHT_C = 19;

    localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(BYTES_PER_WORD - 1);
    localparam logic [WORD_CNT_W-1:0] LAST_WORD = WORD_CNT_W'(KEY_WORDS - 1);

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_GENERATE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW_IDX,
        ST_DRAW_SH,
        ST_EMIT
    } xtkd_state_t;

    typedef struct packed {
        logic seed_load;
        logic step;
    } xtkd_gen_ctrl_t;

    function automatic logic [WORD_W-1:0] xtkd_draw(input logic [WORD_W-1:0] s0,
                                                   input logic [WORD_W-1:0] s3);
        logic [WORD_W-1:0] n;
        n = s0 ^ (s0 << SHIFT_LEFT_A);
        n = n ^ (n >> SHIFT_RIGHT_B) ^ s3 ^ (s3 >> SHIFT_RIGHT_C);
        return n;
    endfunction

endpackage

// ----- src/xtkd_prng.sv -----
// The xorshift128 generator: four state words, seeded on a load, one draw per step.
// Depends on xtkd_pkg for widths, default seeds and the step function.
module xtkd_prng
    import xtkd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  xtkd_gen_ctrl_t       ctrl,
    input  logic [WORD_W-1:0]    seed_a,
    input  logic [WORD_W-1:0]    seed_b,
    input  logic [WORD_W-1:0]    seed_c,
    input  logic [WORD_W-1:0]    seed_d,
    output logic [WORD_W-1:0]    draw
);

    logic [WORD_W-1:0] s0_reg, s1_reg, s2_reg, s3_reg;
    logic [WORD_W-1:0] s0_next, s1_next, s2_next, s3_next;
    logic              any_seed;

    assign draw     = xtkd_draw(s0_reg, s3_reg);
    assign any_seed = (seed_a | seed_b | seed_c | seed_d) != '0;

    always_comb
    begin
        s0_next = s0_reg;
        s1_next = s1_reg;
        s2_next = s2_reg;
        s3_next = s3_reg;
        if (ctrl.seed_load)
        begin
            s0_next = any_seed ? seed_a : DEFAULT_SEED_A;
            s1_next = any_seed ? seed_b : DEFAULT_SEED_B;
            s2_next = any_seed ? seed_c : DEFAULT_SEED_C;
            s3_next = any_seed ? seed_d : DEFAULT_SEED_D;
        end
        else if (ctrl.step)
        begin
            s0_next = s1_reg;
            s1_next = s2_reg;
            s2_next = s3_reg;
            s3_next = draw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

endmodule

// ----- src/xorshift_table_key_derive.sv -----
// Top level of the xorshift table key derivation block: key table, sequencer and output register.
// Depends on xtkd_pkg and instantiates xtkd_prng.
//
//   channel | direction | beat fields                                          | handshake
//   in      | input     | func, table_index, table_word, seed_a..seed_d       | in_valid/in_stall
//   out     | output    | key_word, word_number, last                          | out_valid/out_stall
//
// A load beat writes table_word into the key table and gives no result.
// A generate beat builds, per key word, four bytes of two generator draws each, one draw a
// cycle from the shared generator, then uses the EMIT state to hand the word to the output
// register. The input stalls for that whole sequence and is free again once the sequencer is
// back in IDLE, so a new generate beat is not accepted before the last one is through.
// A stalled output holds the sequencer in EMIT and adds its stall cycles to the sequence.
// Reset clears the sequencer, generator and output valid; the key table is not cleared.
module xorshift_table_key_derive
    import xtkd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [TABLE_AW-1:0]  table_index,
    input  logic [WORD_W-1:0]    table_word,
    input  logic [WORD_W-1:0]    seed_a,
    input  logic [WORD_W-1:0]    seed_b,
    input  logic [WORD_W-1:0]    seed_c,
    input  logic [WORD_W-1:0]    seed_d,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_W-1:0]    key_word,
    output logic [1:0]           word_number,
    output logic                 last
);

    xtkd_state_t            state_reg, state_next;
    xtkd_gen_ctrl_t         gen_ctrl;
    logic [WORD_W-1:0]      draw;
    logic [WORD_W-1:0]      table_mem [TABLE_DEPTH];
    logic [WORD_W-1:0]      rd_data_reg;
    logic [WORD_W-1:0]      build_reg, build_next;
    logic [BYTE_CNT_W-1:0]  byte_cnt_reg, byte_cnt_next;
    logic [WORD_CNT_W-1:0]  word_cnt_reg, word_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]      key_word_reg;
    logic [1:0]             word_number_reg;
    logic                   last_reg;
    logic                   in_accept;
    logic                   out_free;
    logic                   out_load;
    logic [4:0]             byte_shift;
    logic [BYTE_W-1:0]      picked_byte;
    logic [WORD_CNT_W+1:0]  word_cnt_ext;

    assign in_accept    = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign byte_shift   = {draw[WORD_W-1:WORD_W-2], 3'b000};
    assign picked_byte  = BYTE_W'(rd_data_reg >> byte_shift);
    assign word_cnt_ext = {2'b00, word_cnt_reg};

    xtkd_prng u_prng
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (gen_ctrl),
        .seed_a (seed_a),
        .seed_b (seed_b),
        .seed_c (seed_c),
        .seed_d (seed_d),
        .draw   (draw)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && func == FUNC_GENERATE)
                begin
                    state_next = ST_DRAW_IDX;
                end
            end
            ST_DRAW_IDX:
            begin
                state_next = ST_DRAW_SH;
            end
            ST_DRAW_SH:
            begin
                state_next = (byte_cnt_reg == LAST_BYTE) ? ST_EMIT : ST_DRAW_IDX;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (word_cnt_reg == LAST_WORD) ? ST_IDLE : ST_DRAW_IDX;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall           = 1'b1;
        gen_ctrl.seed_load = 1'b0;
        gen_ctrl.step      = 1'b0;
        out_load           = 1'b0;
        build_next         = build_reg;
        byte_cnt_next      = byte_cnt_reg;
        word_cnt_next      = word_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall           = 1'b0;
                gen_ctrl.seed_load = in_accept && func == FUNC_GENERATE;
                byte_cnt_next      = '0;
                word_cnt_next      = '0;
            end
            ST_DRAW_IDX:
            begin
                gen_ctrl.step = 1'b1;
            end
            ST_DRAW_SH:
            begin
                gen_ctrl.step = 1'b1;
                build_next    = {build_reg[WORD_W-BYTE_W-1:0], picked_byte};
                byte_cnt_next = byte_cnt_reg + 1'b1;
            end
            ST_EMIT:
            begin
                out_load = out_free;
                if (out_free)
                begin
                    word_cnt_next = word_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            byte_cnt_reg  <= '0;
            word_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_cnt_reg  <= byte_cnt_next;
            word_cnt_reg  <= word_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        build_reg <= build_next;
        if (out_load)
        begin
            key_word_reg    <= build_reg;
            word_number_reg <= word_cnt_ext[1:0];
            last_reg        <= (word_cnt_reg == LAST_WORD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && func == FUNC_LOAD)
        begin
            table_mem[table_index] <= table_word;
        end
        rd_data_reg <= table_mem[draw[WORD_W-1:WORD_W-TABLE_AW]];
    end

    assign out_valid   = out_valid_reg;
    assign key_word    = key_word_reg;
    assign word_number = word_number_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_gen_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && func == FUNC_GENERATE |=> state_reg == ST_DRAW_IDX)
        else $error("A generate beat did not start the draw sequence.");

    a_draw_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAW_SH |-> $past(state_reg) == ST_DRAW_IDX)
        else $error("A shift draw was not preceded by an index draw.");

    a_last_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> word_number == 2'(KEY_WORDS - 1))
        else $error("The final key word carries the wrong word number.");
`endif

endmodule
